[rtl/core/s2l_pkg.sv]
package s2l_pkg;

    localparam int OUT_FRAC_BITS    = 8;
    localparam int LINEAR_FRAC_BITS = 16;

    localparam int LIN_W   = LINEAR_FRAC_BITS + 1;
    localparam int COEF_W  = 20;
    localparam int PROD_W  = COEF_W + LIN_W;
    localparam int SUM_W   = PROD_W + 2;
    localparam int T_SHIFT = LINEAR_FRAC_BITS - 10;
    localparam int T_W     = 32;
    localparam int ROOT_W  = 31;
    localparam int QUOT_W  = 28;
    localparam int BIT_W   = 5;
    localparam int F_W     = 32;
    localparam int WIDE_W  = 48;
    localparam int MAG_W   = 21;
    localparam int PART_W  = 24;
    localparam int CHUNK_W = 12;
    localparam int Y_W     = PART_W + CHUNK_W;

    localparam int ROOT_STEPS = ROOT_W;
    localparam int LATENCY    = 3 + 4 + 2 * ROOT_STEPS + 3;

    localparam logic [63:0] ONE30      = 64'd1 << 30;
    localparam logic [63:0] T_MAX      = 64'd1 << 31;
    localparam logic [63:0] T_SMALL    = (64'd216 << 30) / 64'd24389;
    localparam logic [63:0] LIN_OFFSET = (64'd432 << 30) + 64'd1566;
    localparam logic [63:0] LIN_SLOPE  = 64'd24389;
    localparam logic [63:0] LIN_DIV    = 64'd3132;

    localparam logic [63:0] LIN_SLOPE_Q  = LIN_SLOPE / LIN_DIV;
    localparam logic [63:0] LIN_SLOPE_R  = LIN_SLOPE % LIN_DIV;
    localparam logic [63:0] LIN_OFFSET_Q = LIN_OFFSET / LIN_DIV;
    localparam logic [63:0] LIN_OFFSET_R = LIN_OFFSET % LIN_DIV;
    localparam int          RECIP_SHIFT  = PART_W + CHUNK_W;
    localparam logic [63:0] LIN_RECIP    = ((64'd1 << RECIP_SHIFT) + LIN_DIV - 64'd1) / LIN_DIV;

    localparam logic [COEF_W-1:0] COEF [3][3] = '{
        '{20'd455029, 20'd394485, 20'd199062},
        '{20'd223004, 20'd749891, 20'd75681},
        '{20'd18619,  20'd114786, 20'd915171}
    };

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_s2l_req;

    typedef struct packed {
        logic [14:0]        lightness;
        logic signed [15:0] green_red_axis;
        logic signed [15:0] blue_yellow_axis;
    } t_s2l_res;

    typedef struct packed {
        logic [T_W-1:0]    t;
        logic              lin_seg;
        logic [ROOT_W-1:0] r;
        logic [QUOT_W-1:0] q;
    } t_s2l_root;

    typedef logic [LIN_W-1:0] t_lin_lut [256];

    function automatic logic [63:0] f_qpow5(logic [63:0] r);
        logic [63:0] p;
        p = r;
        for (int i = 1; i < 5; i++) begin
            p = (p * r) >> 30;
        end
        return p;
    endfunction

    function automatic logic [LIN_W-1:0] f_decode(logic [63:0] c);
        logic [63:0] u;
        logic [63:0] s;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        logic [63:0] lin;
        if (c * 64'd100000 <= 64'd1031475) begin
            return LIN_W'((((64'd5 * c) << LINEAR_FRAC_BITS) + 64'd8236) / 64'd16473);
        end
        u  = (((64'd1000 * c + 64'd14025) << 30) + 64'd134512) / 64'd269025;
        s  = (u * u + (ONE30 >> 1)) >> 30;
        lo = 64'd0;
        hi = ONE30 + 64'd1;
        for (int it = 0; it < 40; it++) begin
            if (hi - lo > 64'd1) begin
                mid = lo + ((hi - lo) >> 1);
                if (f_qpow5(mid) <= s) begin
                    lo = mid;
                end else begin
                    hi = mid;
                end
            end
        end
        lin = (s * lo + (ONE30 >> 1)) >> 30;
        return LIN_W'((lin + (64'd1 << (29 - LINEAR_FRAC_BITS))) >> (30 - LINEAR_FRAC_BITS));
    endfunction

    function automatic t_lin_lut f_build_lut();
        t_lin_lut lut;
        for (int c = 0; c < 256; c++) begin
            lut[c] = f_decode(64'(c));
        end
        return lut;
    endfunction

    localparam t_lin_lut LIN_LUT = f_build_lut();

endpackage

[rtl/core/s2l_xyz.sv]
module s2l_xyz (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  s2l_pkg::t_s2l_req          i_request,
    output logic                       o_valid,
    output logic [s2l_pkg::T_W-1:0]    o_t [3]
);
    import s2l_pkg::*;

    logic              r_v0;
    logic              r_v1;
    logic              r_v2;
    logic [LIN_W-1:0]  r_lin [3];
    logic [PROD_W-1:0] r_prod [3][3];
    logic [T_W-1:0]    r_t [3];
    logic [SUM_W-1:0]  n_sum [3];
    logic [SUM_W-1:0]  n_tw [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v0 <= i_valid;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lin[0] <= LIN_LUT[i_request.red];
        r_lin[1] <= LIN_LUT[i_request.green];
        r_lin[2] <= LIN_LUT[i_request.blue];
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                r_prod[i][j] <= PROD_W'(COEF[i][j]) * PROD_W'(r_lin[j]);
            end
        end
        for (int i = 0; i < 3; i++) begin
            if (n_tw[i] > SUM_W'(T_MAX)) begin
                r_t[i] <= T_W'(T_MAX);
            end else begin
                r_t[i] <= T_W'(n_tw[i]);
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_sum[i] = SUM_W'(r_prod[i][0]) + SUM_W'(r_prod[i][1]) + SUM_W'(r_prod[i][2]);
            n_tw[i]  = (n_sum[i] + (SUM_W'(1) << (T_SHIFT - 1))) >> T_SHIFT;
        end
    end

    assign o_valid = r_v2;
    assign o_t     = r_t;

endmodule

[rtl/core/s2l_cbrt_step.sv]
module s2l_cbrt_step (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [s2l_pkg::BIT_W-1:0]   i_bit,
    input  s2l_pkg::t_s2l_root          i_st,
    output logic                        o_valid,
    output s2l_pkg::t_s2l_root          o_st
);
    import s2l_pkg::*;

    logic              r_va;
    logic              r_vb;
    t_s2l_root         r_sta;
    t_s2l_root         r_stb;
    logic [ROOT_W-1:0] r_mid;
    logic [32:0]       r_sq;
    logic [ROOT_W-1:0] n_mid;
    logic [63:0]       n_cube;
    t_s2l_root         n_st;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else begin
            r_va <= i_valid;
            r_vb <= r_va;
        end
    end

    assign n_mid = i_st.r | (ROOT_W'(1) << i_bit);

    always_ff @(posedge i_clk) begin
        r_sta <= i_st;
        r_mid <= n_mid;
        r_sq  <= 33'((64'(n_mid) * 64'(n_mid)) >> 30);
        r_stb <= n_st;
    end

    always_comb begin
        n_cube = (64'(r_sq) * 64'(r_mid)) >> 30;
        n_st   = r_sta;
        if (n_cube <= 64'(r_sta.t)) begin
            n_st.r = r_mid;
        end
    end

    assign o_valid = r_vb;
    assign o_st    = r_stb;

endmodule

[rtl/core/s2l_lab_f.sv]
module s2l_lab_f (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic [s2l_pkg::T_W-1:0]   i_t,
    output logic                      o_valid,
    output logic [s2l_pkg::F_W-1:0]   o_f
);
    import s2l_pkg::*;

    logic              r_v;
    logic              r_v2;
    logic              r_v3;
    logic              r_v4;
    t_s2l_root         r_st;
    t_s2l_root         r_st2;
    t_s2l_root         r_st3;
    t_s2l_root         r_st4;
    logic [Y_W-1:0]    r_y;
    logic [Y_W-1:0]    r_y2;
    logic [PART_W-1:0] r_qh;
    logic [PART_W-1:0] r_chunk;
    t_s2l_root         n_st3;
    t_s2l_root         n_st4;
    logic              w_v  [ROOT_STEPS+1];
    t_s2l_root         w_st [ROOT_STEPS+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v  <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v  <= i_valid;
            r_v2 <= r_v;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        r_st.t       <= i_t;
        r_st.lin_seg <= (64'(i_t) <= T_SMALL);
        r_st.r       <= '0;
        r_st.q       <= QUOT_W'(64'(i_t[PART_W-1:0]) * LIN_SLOPE_Q + LIN_OFFSET_Q);
        r_y          <= Y_W'(64'(i_t[PART_W-1:0]) * LIN_SLOPE_R + LIN_OFFSET_R);
    end

    always_ff @(posedge i_clk) begin
        r_st2   <= r_st;
        r_y2    <= r_y;
        r_qh    <= PART_W'((64'(r_y[Y_W-1:CHUNK_W]) * LIN_RECIP) >> RECIP_SHIFT);
        r_st3   <= n_st3;
        r_chunk <= PART_W'(64'(r_y2) - ((64'(r_qh) * LIN_DIV) << CHUNK_W));
        r_st4   <= n_st4;
    end

    always_comb begin
        n_st3   = r_st2;
        n_st3.q = r_st2.q + QUOT_W'(64'(r_qh) << CHUNK_W);
        n_st4   = r_st3;
        n_st4.q = r_st3.q + QUOT_W'((64'(r_chunk) * LIN_RECIP) >> RECIP_SHIFT);
    end

    assign w_v[0]  = r_v4;
    assign w_st[0] = r_st4;

    for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_step
        s2l_cbrt_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_v[k]),
            .i_bit   (BIT_W'(ROOT_STEPS - 1 - k)),
            .i_st    (w_st[k]),
            .o_valid (w_v[k+1]),
            .o_st    (w_st[k+1])
        );
    end

    assign o_valid = w_v[ROOT_STEPS];
    assign o_f     = w_st[ROOT_STEPS].lin_seg ? F_W'(w_st[ROOT_STEPS].q)
                                              : F_W'(w_st[ROOT_STEPS].r);

endmodule

[rtl/core/s2l_out.sv]
module s2l_out (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic [s2l_pkg::F_W-1:0]   i_f [3],
    output logic                      o_valid,
    output s2l_pkg::t_s2l_res         o_result
);
    import s2l_pkg::*;

    logic                     r_v1;
    logic                     r_v2;
    logic                     r_v3;
    logic signed [WIDE_W-1:0] r_w [3];
    logic                     r_neg [3];
    logic [MAG_W-1:0]         r_m [3];
    t_s2l_res                 r_res;
    logic signed [WIDE_W-1:0] n_f [3];
    logic [WIDE_W-1:0]        n_abs [3];
    logic [WIDE_W-1:0]        n_rm [3];

    function automatic logic signed [15:0] f_sat(logic neg, logic [MAG_W-1:0] m);
        if (neg) begin
            if (m > MAG_W'(32768)) begin
                return 16'sh8000;
            end
            return 16'(-m);
        end
        if (m > MAG_W'(32767)) begin
            return 16'sh7fff;
        end
        return 16'(m);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_f[i] = signed'(WIDE_W'(i_f[i]));
        end
    end

    always_ff @(posedge i_clk) begin
        r_w[0] <= WIDE_W'(116) * n_f[1] - signed'(WIDE_W'(64'd16 << 30));
        r_w[1] <= WIDE_W'(500) * (n_f[0] - n_f[1]);
        r_w[2] <= WIDE_W'(200) * (n_f[1] - n_f[2]);
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_abs[i] = r_w[i][WIDE_W-1] ? WIDE_W'(-r_w[i]) : WIDE_W'(r_w[i]);
            n_rm[i]  = (n_abs[i] + (WIDE_W'(1) << (29 - OUT_FRAC_BITS)))
                       >> (30 - OUT_FRAC_BITS);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_neg[i] <= r_w[i][WIDE_W-1];
            if (n_rm[i] > WIDE_W'(1 << 20)) begin
                r_m[i] <= MAG_W'(1 << 20);
            end else begin
                r_m[i] <= MAG_W'(n_rm[i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v2) begin
            if (r_neg[0]) begin
                r_res.lightness <= '0;
            end else if (r_m[0] > MAG_W'(32767)) begin
                r_res.lightness <= 15'd32767;
            end else begin
                r_res.lightness <= 15'(r_m[0]);
            end
            r_res.green_red_axis   <= f_sat(r_neg[1], r_m[1]);
            r_res.blue_yellow_axis <= f_sat(r_neg[2], r_m[2]);
        end
    end

    assign o_valid  = r_v3;
    assign o_result = r_res;

endmodule

[rtl/core/srgb_to_cielab.sv]
// Channel    Direction  Signals                  Meaning
// request    in         start, busy, i_request   one sRGB pixel (red, green, blue)
// result     out        o_done, o_result         CIELAB L, a, b with 8 fraction bits
//
// A new request is taken in every cycle, and busy is always low.
// Each result passes through three stages for the matrix, four to set up the
// Lab function, two per bit of the 31-bit cube root, and three for the final
// scaling and rounding.
// Reset clears only the valid bits of the pipeline.
// The receiver cannot stall, so no stage ever holds.
module srgb_to_cielab (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  s2l_pkg::t_s2l_req  i_request,
    output logic               o_done,
    output s2l_pkg::t_s2l_res  o_result
);
    import s2l_pkg::*;

    logic           w_xyz_v;
    logic [T_W-1:0] w_t [3];
    logic           w_f_v [3];
    logic [F_W-1:0] w_f [3];

    assign busy = 1'b0;

    s2l_xyz u_xyz (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (start && !busy),
        .i_request (i_request),
        .o_valid   (w_xyz_v),
        .o_t       (w_t)
    );

    for (genvar i = 0; i < 3; i++) begin : g_lab
        s2l_lab_f u_lab_f (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_xyz_v),
            .i_t     (w_t[i]),
            .o_valid (w_f_v[i]),
            .o_f     (w_f[i])
        );
    end

    s2l_out u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_f_v[1]),
        .i_f      (w_f),
        .o_valid  (o_done),
        .o_result (o_result)
    );

`ifndef SYNTH
    a_done_has_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start, LATENCY))
        else $error("result without a matching request");

    a_lightness_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_result.lightness <= 15'd25600)
        else $error("lightness above 100");

    a_lanes_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_f_v[0] == w_f_v[1] && w_f_v[1] == w_f_v[2])
        else $error("lab lanes out of step");
`endif

endmodule
